@@ src/mer_pkg.sv @@
// ----------------------------------------------------------------------------
// mer_pkg
// Shared widths, codes and structs of the midpoint ellipse rasterizer.
// ----------------------------------------------------------------------------
package mer_pkg;

    localparam int COORD_WIDTH = 10;
    localparam int CENTER_W    = 10;
    localparam int RADIUS_W    = 9;
    localparam int PIX_W       = COORD_WIDTH + 2;
    localparam int DEC_W       = 44;
    localparam int SQ_W        = 2 * RADIUS_W;
    localparam int TXSQ_W      = 2 * COORD_WIDTH + 2;
    localparam int TYSQ_W      = 2 * COORD_WIDTH;

    // multiplier operand widths: a takes radii, their squares, 2x+1 or |y-1|, b the rest
    localparam int MUL_A_W = (SQ_W > COORD_WIDTH + 1) ? SQ_W : COORD_WIDTH + 1;
    localparam int MUL_B_W = (SQ_W + 2 > TXSQ_W) ? SQ_W + 2 : TXSQ_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int EXT_W   = (PIX_W > CENTER_W) ? PIX_W : CENTER_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = CENTER_W;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_X = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_Y = 2'd3;

    typedef logic [1:0] mac_mode_t;

    localparam mac_mode_t MAC_LOAD = 2'd0;
    localparam mac_mode_t MAC_SEED = 2'd1;
    localparam mac_mode_t MAC_ADD  = 2'd2;
    localparam mac_mode_t MAC_SUB  = 2'd3;

    typedef struct packed {
        logic                    start;
        mac_mode_t               mode;
        logic [MUL_A_W-1:0]      a;
        logic [MUL_B_W-1:0]      b;
        logic signed [DEC_W-1:0] seed;
    } mac_cmd_t;

    typedef struct packed {
        logic                    done;
        logic signed [DEC_W-1:0] acc;
    } mac_rsp_t;

    typedef struct packed {
        logic                   load;
        logic [COORD_WIDTH-1:0] x;
        logic [COORD_WIDTH-1:0] y;
        logic [CENTER_W-1:0]    cx;
        logic [CENTER_W-1:0]    cy;
        logic                   last;
    } emit_load_t;

endpackage

@@ src/mer_if.sv @@
// ----------------------------------------------------------------------------
// mer_if
// Valid/ready channels of the rasterizer: step commands in, pixels out.
// ----------------------------------------------------------------------------
interface mer_step_if import mer_pkg::*; ();
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

interface mer_pixel_if import mer_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [PIX_W-1:0] pixel_x;
    logic signed [PIX_W-1:0] pixel_y;
    logic                    final_pixel;

    modport source (output valid, output pixel_x, output pixel_y, output final_pixel,
                    input ready);
    modport sink (input valid, input pixel_x, input pixel_y, input final_pixel,
                  output ready);
endinterface

@@ src/midpoint_ellipse_rasterizer.sv @@
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer
// Two-region midpoint ellipse walk; a plain step sends one point's four pixels.
//
//   channel   dir   payload                              transfer when
//   step      in    restart                              valid && ready
//   pixel     out   pixel_x, pixel_y, final_pixel        valid && ready
//   cfg       in    cfg_index, cfg_data                  cfg_we
//
// Every multiply-accumulate runs in turn on the shared unit; a step at the
// change to region 2 also runs the region-2 load, as does a restart if
// region 2 starts at once.
// Reset leaves the walk finished; steps before a restart send nothing.
// The next step is taken while the four pixels of the last one drain; its
// pixels wait in the sequencer until the pixel buffer is free.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer import mer_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    mer_step_if.sink              step,
    mer_pixel_if.source           pixel
);

    logic [CENTER_W-1:0] center_x_reg;
    logic [CENTER_W-1:0] center_y_reg;
    logic [RADIUS_W-1:0] radius_x_reg;
    logic [RADIUS_W-1:0] radius_y_reg;
    mac_cmd_t            mac_cmd;
    mac_rsp_t            mac_rsp;
    emit_load_t          emit_ld;
    logic                emit_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            radius_x_reg <= RADIUS_W'(1);
            radius_y_reg <= RADIUS_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CENTER_X: center_x_reg <= cfg_data[CENTER_W-1:0];
                CFG_CENTER_Y: center_y_reg <= cfg_data[CENTER_W-1:0];
                CFG_RADIUS_X: radius_x_reg <= cfg_data[RADIUS_W-1:0];
                CFG_RADIUS_Y: radius_y_reg <= cfg_data[RADIUS_W-1:0];
                default:      ;
            endcase
        end
    end

    mer_seq u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .center_x  (center_x_reg),
        .center_y  (center_y_reg),
        .radius_x  (radius_x_reg),
        .radius_y  (radius_y_reg),
        .mac_cmd   (mac_cmd),
        .mac_rsp   (mac_rsp),
        .emit_ld   (emit_ld),
        .emit_free (emit_free)
    );

    mer_mac u_mac
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mac_cmd),
        .rsp   (mac_rsp)
    );

    mer_emit u_emit
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ld    (emit_ld),
        .free  (emit_free),
        .pixel (pixel)
    );

endmodule

@@ src/mer_mac.sv @@
// ----------------------------------------------------------------------------
// mer_mac
// Shared multiply-accumulate unit: registers the product, accumulates it in the next.
// ----------------------------------------------------------------------------
module mer_mac import mer_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mac_cmd_t cmd,
    output mac_rsp_t rsp
);

    logic [PROD_W-1:0]       prod_reg;
    mac_mode_t               mode_reg;
    logic signed [DEC_W-1:0] seed_reg;
    logic signed [DEC_W-1:0] acc_reg;
    logic                    pend_reg;
    logic                    done_reg;
    logic signed [DEC_W-1:0] prod_ext;
    logic signed [DEC_W-1:0] acc_next;

    assign prod_ext = signed'(DEC_W'(prod_reg));

    always_comb
    begin
        unique case (mode_reg)
            MAC_LOAD: acc_next = prod_ext;
            MAC_SEED: acc_next = seed_reg + prod_ext;
            MAC_ADD:  acc_next = acc_reg + prod_ext;
            MAC_SUB:  acc_next = acc_reg - prod_ext;
            default:  acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= cmd.start;
            done_reg <= pend_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            prod_reg <= PROD_W'(cmd.a) * PROD_W'(cmd.b);
            mode_reg <= cmd.mode;
            seed_reg <= cmd.seed;
        end
        if (pend_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.acc  = acc_reg;

endmodule

@@ src/mer_emit.sv @@
// ----------------------------------------------------------------------------
// mer_emit
// Holds one walk point and sends its four mirrored pixels, one per transfer.
// ----------------------------------------------------------------------------
module mer_emit import mer_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  emit_load_t ld,
    output logic       free,
    mer_pixel_if.source pixel
);

    localparam logic [1:0] LAST_PIX = 2'd3;

    logic                   valid_reg;
    logic [1:0]             cnt_reg;
    logic [COORD_WIDTH-1:0] x_reg;
    logic [COORD_WIDTH-1:0] y_reg;
    logic [CENTER_W-1:0]    cx_reg;
    logic [CENTER_W-1:0]    cy_reg;
    logic                   last_reg;
    logic [EXT_W-1:0]       sum_x;
    logic [EXT_W-1:0]       sum_y;
    logic                   xfer;

    assign xfer = valid_reg && pixel.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else if (ld.load)
        begin
            valid_reg <= 1'b1;
            cnt_reg   <= '0;
        end
        else if (xfer)
        begin
            if (cnt_reg == LAST_PIX)
            begin
                valid_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld.load)
        begin
            x_reg    <= ld.x;
            y_reg    <= ld.y;
            cx_reg   <= ld.cx;
            cy_reg   <= ld.cy;
            last_reg <= ld.last;
        end
    end

    // order: (+x,+y) (+x,-y) (-x,+y) (-x,-y)
    always_comb
    begin
        if (cnt_reg[1])
        begin
            sum_x = EXT_W'(cx_reg) - EXT_W'(x_reg);
        end
        else
        begin
            sum_x = EXT_W'(cx_reg) + EXT_W'(x_reg);
        end
        if (cnt_reg[0])
        begin
            sum_y = EXT_W'(cy_reg) - EXT_W'(y_reg);
        end
        else
        begin
            sum_y = EXT_W'(cy_reg) + EXT_W'(y_reg);
        end
    end

    assign free              = !valid_reg;
    assign pixel.valid       = valid_reg;
    assign pixel.pixel_x     = sum_x[PIX_W-1:0];
    assign pixel.pixel_y     = sum_y[PIX_W-1:0];
    assign pixel.final_pixel = last_reg && (cnt_reg == LAST_PIX);

endmodule

@@ src/mer_seq.sv @@
// ----------------------------------------------------------------------------
// mer_seq
// Ellipse walk sequencer: drives the shared multiply-accumulate unit through
// radius squares, restart seed, decision update, region test, region-2 load.
// ----------------------------------------------------------------------------
module mer_seq import mer_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    mer_step_if.sink            step,
    input  logic [CENTER_W-1:0] center_x,
    input  logic [CENTER_W-1:0] center_y,
    input  logic [RADIUS_W-1:0] radius_x,
    input  logic [RADIUS_W-1:0] radius_y,
    output mac_cmd_t            mac_cmd,
    input  mac_rsp_t            mac_rsp,
    output emit_load_t          emit_ld,
    input  logic                emit_free
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_SQ_RX   = 5'd1;
    localparam logic [4:0] S_SQ_RY   = 5'd2;
    localparam logic [4:0] S_RS_A    = 5'd3;
    localparam logic [4:0] S_RS_B    = 5'd4;
    localparam logic [4:0] S_RS_C    = 5'd5;
    localparam logic [4:0] S_R1_A    = 5'd6;
    localparam logic [4:0] S_R1_B    = 5'd7;
    localparam logic [4:0] S_R2_A    = 5'd8;
    localparam logic [4:0] S_R2_X    = 5'd9;
    localparam logic [4:0] S_R2_B    = 5'd10;
    localparam logic [4:0] S_SET_A   = 5'd11;
    localparam logic [4:0] S_SET_B   = 5'd12;
    localparam logic [4:0] S_L2_TX   = 5'd13;
    localparam logic [4:0] S_L2_TY   = 5'd14;
    localparam logic [4:0] S_L2_A    = 5'd15;
    localparam logic [4:0] S_L2_B    = 5'd16;
    localparam logic [4:0] S_L2_C    = 5'd17;
    localparam logic [4:0] S_SET_END = 5'd18;

    logic [4:0]              state_reg, state_next;
    logic                    issued_reg, issued_next;
    logic [COORD_WIDTH-1:0]  x_reg, x_next;
    logic [COORD_WIDTH-1:0]  y_reg, y_next;
    logic signed [DEC_W-1:0] p_reg, p_next;
    logic                    r2_reg, r2_next;
    logic                    fin_reg, fin_next;
    logic                    restart_reg, restart_next;
    logic                    neg_reg, neg_next;
    logic [SQ_W-1:0]         rx2_reg, rx2_next;
    logic [SQ_W-1:0]         ry2_reg, ry2_next;
    logic [TXSQ_W-1:0]       txsq_reg, txsq_next;
    logic [TYSQ_W-1:0]       tysq_reg, tysq_next;

    logic                    is_op;
    logic                    fin_now;
    logic                    p_le_zero;
    logic [COORD_WIDTH:0]    tx;
    logic [COORD_WIDTH-1:0]  ty_abs;

    assign tx        = {x_reg, 1'b1};
    // |y - 1| with y taken as an unsigned walk coordinate
    assign ty_abs    = (y_reg == '0) ? COORD_WIDTH'(1) : y_reg - COORD_WIDTH'(1);
    assign fin_now   = fin_reg || (r2_reg && (y_reg == '0));
    assign p_le_zero = p_reg[DEC_W-1] || (p_reg == '0);
    assign step.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        issued_next  = issued_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        p_next       = p_reg;
        r2_next      = r2_reg;
        fin_next     = fin_reg;
        restart_next = restart_reg;
        neg_next     = neg_reg;
        rx2_next     = rx2_reg;
        ry2_next     = ry2_reg;
        txsq_next    = txsq_reg;
        tysq_next    = tysq_reg;
        is_op        = 1'b0;
        mac_cmd      = '0;
        mac_cmd.seed = p_reg;
        emit_ld.load = 1'b0;
        emit_ld.x    = x_reg;
        emit_ld.y    = y_reg;
        emit_ld.cx   = center_x;
        emit_ld.cy   = center_y;
        emit_ld.last = fin_now;

        unique case (state_reg)
            S_IDLE:
            begin
                if (step.valid)
                begin
                    if (step.restart)
                    begin
                        x_next  = '0;
                        y_next  = COORD_WIDTH'(radius_y);
                        r2_next = 1'b0;
                        if ((radius_x == '0) || (radius_y == '0))
                        begin
                            p_next   = '0;
                            fin_next = 1'b1;
                        end
                        else
                        begin
                            fin_next     = 1'b0;
                            restart_next = 1'b1;
                            state_next   = S_SQ_RX;
                        end
                    end
                    else if (!fin_reg)
                    begin
                        restart_next = 1'b0;
                        state_next   = S_SQ_RX;
                    end
                end
            end
            S_SQ_RX:
            begin
                is_op     = 1'b1;
                mac_cmd.a = MUL_A_W'(radius_x);
                mac_cmd.b = MUL_B_W'(radius_x);
                if (mac_rsp.done)
                begin
                    rx2_next   = mac_rsp.acc[SQ_W-1:0];
                    state_next = S_SQ_RY;
                end
            end
            S_SQ_RY:
            begin
                is_op     = 1'b1;
                mac_cmd.a = MUL_A_W'(radius_y);
                mac_cmd.b = MUL_B_W'(radius_y);
                if (mac_rsp.done)
                begin
                    ry2_next = mac_rsp.acc[SQ_W-1:0];
                    if (restart_reg)
                    begin
                        state_next = S_RS_A;
                    end
                    else if (!r2_reg)
                    begin
                        x_next   = x_reg + COORD_WIDTH'(1);
                        neg_next = p_reg[DEC_W-1];
                        if (!p_reg[DEC_W-1])
                        begin
                            y_next = y_reg - COORD_WIDTH'(1);
                        end
                        state_next = S_R1_A;
                    end
                    else
                    begin
                        neg_next = p_le_zero;
                        y_next   = y_reg - COORD_WIDTH'(1);
                        if (p_le_zero)
                        begin
                            x_next     = x_reg + COORD_WIDTH'(1);
                            state_next = S_R2_A;
                        end
                        else
                        begin
                            state_next = S_R2_X;
                        end
                    end
                end
            end
            // restart: ry^2 - rx^2*ry + floor(rx^2/4)
            S_RS_A:
            begin
                is_op     = 1'b1;
                mac_cmd.a = MUL_A_W'(ry2_reg);
                mac_cmd.b = MUL_B_W'(1);
                if (mac_rsp.done)
                begin
                    state_next = S_RS_B;
                end
            end
            S_RS_B:
            begin
                is_op        = 1'b1;
                mac_cmd.mode = MAC_SUB;
                mac_cmd.a    = MUL_A_W'(rx2_reg);
                mac_cmd.b    = MUL_B_W'(radius_y);
                if (mac_rsp.done)
                begin
                    state_next = S_RS_C;
                end
            end
            S_RS_C:
            begin
                is_op        = 1'b1;
                mac_cmd.mode = MAC_ADD;
                mac_cmd.a    = MUL_A_W'(rx2_reg >> 2);
                mac_cmd.b    = MUL_B_W'(1);
                if (mac_rsp.done)
                begin
                    p_next     = mac_rsp.acc;
                    state_next = S_SET_A;
                end
            end
            // region 1: p + ry^2*(2x+1) [- rx^2*2y]
            S_R1_A:
            begin
                is_op        = 1'b1;
                mac_cmd.mode = MAC_SEED;
                mac_cmd.a    = MUL_A_W'(ry2_reg);
                mac_cmd.b    = MUL_B_W'(tx);
                if (mac_rsp.done)
                begin
                    if (neg_reg)
                    begin
                        p_next     = mac_rsp.acc;
                        state_next = S_SET_A;
                    end
                    else
                    begin
                        state_next = S_R1_B;
                    end
                end
            end
            S_R1_B:
            begin
                is_op        = 1'b1;
                mac_cmd.mode = MAC_SUB;
                mac_cmd.a    = MUL_A_W'(rx2_reg);
                mac_cmd.b    = MUL_B_W'({y_reg, 1'b0});
                if (mac_rsp.done)
                begin
                    p_next     = mac_rsp.acc;
                    state_next = S_SET_A;
                end
            end
            // region 2, scaled by 4: [p + ry^2*8x] + rx^2*4 - rx^2*8y
            S_R2_A:
            begin
                is_op        = 1'b1;
                mac_cmd.mode = MAC_SEED;
                mac_cmd.a    = MUL_A_W'(ry2_reg);
                mac_cmd.b    = MUL_B_W'({x_reg, 3'b000});
                if (mac_rsp.done)
                begin
                    state_next = S_R2_X;
                end
            end
            S_R2_X:
            begin
                is_op        = 1'b1;
                mac_cmd.mode = neg_reg ? MAC_ADD : MAC_SEED;
                mac_cmd.a    = MUL_A_W'(rx2_reg);
                mac_cmd.b    = MUL_B_W'(4);
                if (mac_rsp.done)
                begin
                    state_next = S_R2_B;
                end
            end
            S_R2_B:
            begin
                is_op        = 1'b1;
                mac_cmd.mode = MAC_SUB;
                mac_cmd.a    = MUL_A_W'(rx2_reg);
                mac_cmd.b    = MUL_B_W'({y_reg, 3'b000});
                if (mac_rsp.done)
                begin
                    p_next     = mac_rsp.acc;
                    state_next = S_SET_A;
                end
            end
            // region test: rx^2*y - ry^2*x < 0 leaves region 1
            S_SET_A:
            begin
                if (r2_reg)
                begin
                    state_next = S_SET_END;
                end
                else
                begin
                    is_op     = 1'b1;
                    mac_cmd.a = MUL_A_W'(rx2_reg);
                    mac_cmd.b = MUL_B_W'(y_reg);
                    if (mac_rsp.done)
                    begin
                        state_next = S_SET_B;
                    end
                end
            end
            S_SET_B:
            begin
                is_op        = 1'b1;
                mac_cmd.mode = MAC_SUB;
                mac_cmd.a    = MUL_A_W'(ry2_reg);
                mac_cmd.b    = MUL_B_W'(x_reg);
                if (mac_rsp.done)
                begin
                    if (mac_rsp.acc[DEC_W-1])
                    begin
                        r2_next    = 1'b1;
                        state_next = S_L2_TX;
                    end
                    else
                    begin
                        state_next = S_SET_END;
                    end
                end
            end
            // region-2 load: ry^2*(2x+1)^2 + 4rx^2*(y-1)^2 - 4rx^2*ry^2
            S_L2_TX:
            begin
                is_op     = 1'b1;
                mac_cmd.a = MUL_A_W'(tx);
                mac_cmd.b = MUL_B_W'(tx);
                if (mac_rsp.done)
                begin
                    txsq_next  = mac_rsp.acc[TXSQ_W-1:0];
                    state_next = S_L2_TY;
                end
            end
            S_L2_TY:
            begin
                is_op     = 1'b1;
                mac_cmd.a = MUL_A_W'(ty_abs);
                mac_cmd.b = MUL_B_W'(ty_abs);
                if (mac_rsp.done)
                begin
                    tysq_next  = mac_rsp.acc[TYSQ_W-1:0];
                    state_next = S_L2_A;
                end
            end
            S_L2_A:
            begin
                is_op     = 1'b1;
                mac_cmd.a = MUL_A_W'(ry2_reg);
                mac_cmd.b = MUL_B_W'(txsq_reg);
                if (mac_rsp.done)
                begin
                    state_next = S_L2_B;
                end
            end
            S_L2_B:
            begin
                is_op        = 1'b1;
                mac_cmd.mode = MAC_ADD;
                mac_cmd.a    = MUL_A_W'(rx2_reg);
                mac_cmd.b    = MUL_B_W'({tysq_reg, 2'b00});
                if (mac_rsp.done)
                begin
                    state_next = S_L2_C;
                end
            end
            S_L2_C:
            begin
                is_op        = 1'b1;
                mac_cmd.mode = MAC_SUB;
                mac_cmd.a    = MUL_A_W'(rx2_reg);
                mac_cmd.b    = MUL_B_W'({ry2_reg, 2'b00});
                if (mac_rsp.done)
                begin
                    p_next     = mac_rsp.acc;
                    state_next = S_SET_END;
                end
            end
            S_SET_END:
            begin
                if (restart_reg)
                begin
                    fin_next   = fin_now;
                    state_next = S_IDLE;
                end
                else if (emit_free)
                begin
                    emit_ld.load = 1'b1;
                    fin_next     = fin_now;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        mac_cmd.start = is_op && !issued_reg;
        if (mac_cmd.start)
        begin
            issued_next = 1'b1;
        end
        if (mac_rsp.done)
        begin
            issued_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            issued_reg  <= 1'b0;
            x_reg       <= '0;
            y_reg       <= '0;
            p_reg       <= '0;
            r2_reg      <= 1'b0;
            fin_reg     <= 1'b1;
            restart_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            issued_reg  <= issued_next;
            x_reg       <= x_next;
            y_reg       <= y_next;
            p_reg       <= p_next;
            r2_reg      <= r2_next;
            fin_reg     <= fin_next;
            restart_reg <= restart_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        rx2_reg  <= rx2_next;
        ry2_reg  <= ry2_next;
        txsq_reg <= txsq_next;
        tysq_reg <= tysq_next;
    end

endmodule

@@ src/mer_checker.sv @@
// ----------------------------------------------------------------------------
// mer_checker
// Port-level checks of the rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module mer_checker import mer_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             pixel_valid,
    input logic             pixel_ready,
    input logic [PIX_W-1:0] pixel_x,
    input logic [PIX_W-1:0] pixel_y,
    input logic             final_pixel
);

    // a stalled pixel stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && !pixel_ready |=> pixel_valid)
    else $error("pixel valid dropped under stall");

    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && !pixel_ready |=> $stable(pixel_x) && $stable(pixel_y))
    else $error("pixel payload changed under stall");

    // the first pixel of a point is never the closing one
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pixel_valid) |-> !final_pixel)
    else $error("final flag on first pixel of a point");

    // nothing follows directly after the closing pixel transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_ready && final_pixel |=> !pixel_valid)
    else $error("pixel offered right after the final pixel");

endmodule

bind midpoint_ellipse_rasterizer mer_checker u_mer_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .pixel_valid (pixel.valid),
    .pixel_ready (pixel.ready),
    .pixel_x     (pixel.pixel_x),
    .pixel_y     (pixel.pixel_y),
    .final_pixel (pixel.final_pixel)
);

@@ tb/midpoint_ellipse_rasterizer_tb.sv @@
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer_tb
// Walks ellipses of many centers and radii through the rasterizer and checks
// every pixel against a cycle-free model of the two-region midpoint walk,
// under random idling on the step and pixel channels.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer_tb;
    import mer_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 64;
    localparam int RANDOM_ITEMS  = 430;
    localparam int CENTER_MAX    = (1 << CENTER_W) - 1;
    localparam int RADIUS_MAX    = (1 << RADIUS_W) - 1;

    localparam logic [CFG_IDX_W-1:0] REG_LIST [4] =
        '{CFG_CENTER_X, CFG_CENTER_Y, CFG_RADIUS_X, CFG_RADIUS_Y};

    typedef struct packed {
        logic signed [PIX_W-1:0] px;
        logic signed [PIX_W-1:0] py;
        logic                    last;
    } pixel_t;

    // tracks the walk and holds the pixels still owed by the block
    class ellipse_walk_model;
        logic [CENTER_W-1:0]    cen_x, cen_y;
        logic [RADIUS_W-1:0]    rad_x, rad_y;
        logic [COORD_WIDTH-1:0] pos_x, pos_y;
        longint                 err_term;
        bit                     second_half;
        bit                     complete;
        pixel_t                 pending[$];
        int                     errors;
        int                     checked;

        function new();
            cen_x       = '0;
            cen_y       = '0;
            rad_x       = 1;
            rad_y       = 1;
            pos_x       = '0;
            pos_y       = '0;
            err_term    = 0;
            second_half = 1'b0;
            complete    = 1'b1;
            errors      = 0;
            checked     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_CENTER_X: cen_x = val[CENTER_W-1:0];
                CFG_CENTER_Y: cen_y = val[CENTER_W-1:0];
                CFG_RADIUS_X: rad_x = val[RADIUS_W-1:0];
                CFG_RADIUS_Y: rad_y = val[RADIUS_W-1:0];
                default: ;
            endcase
        endfunction

        function bit slope_is_shallow();
            longint rx2, ry2;
            rx2 = longint'(rad_x) * longint'(rad_x);
            ry2 = longint'(rad_y) * longint'(rad_y);
            return 2 * ry2 * longint'(pos_x) <= 2 * rx2 * longint'(pos_y);
        endfunction

        // switch to the second region once the slope passes -1, end at y = 0
        function void check_region_change();
            longint rx2, ry2, tx, ty;
            rx2 = longint'(rad_x) * longint'(rad_x);
            ry2 = longint'(rad_y) * longint'(rad_y);
            if (!second_half && !slope_is_shallow()) begin
                tx = 2 * longint'(pos_x) + 1;
                ty = longint'(pos_y) - 1;
                second_half = 1'b1;
                err_term = ry2 * tx * tx + 4 * rx2 * ty * ty - 4 * rx2 * ry2;
            end
            if (second_half && pos_y == 0)
                complete = 1'b1;
        endfunction

        function void push_pixel(longint x, longint y, bit last);
            pixel_t p;
            p.px   = PIX_W'(x);
            p.py   = PIX_W'(y);
            p.last = last;
            pending.push_back(p);
        endfunction

        function void note_step(bit restart);
            longint rx2, ry2, x, y, cx, cy;
            rx2 = longint'(rad_x) * longint'(rad_x);
            ry2 = longint'(rad_y) * longint'(rad_y);
            if (restart) begin
                pos_x       = '0;
                pos_y       = COORD_WIDTH'(rad_y);
                second_half = 1'b0;
                err_term    = 0;
                if (rad_x == 0 || rad_y == 0) begin
                    complete = 1'b1;
                    return;
                end
                complete = 1'b0;
                err_term = ry2 - rx2 * longint'(rad_y) + rx2 / 4;
                check_region_change();
                return;
            end
            if (complete)
                return;
            if (!second_half) begin
                pos_x = pos_x + 1'b1;
                if (err_term < 0) begin
                    err_term += 2 * ry2 * longint'(pos_x) + ry2;
                end
                else begin
                    pos_y = pos_y - 1'b1;
                    err_term += 2 * ry2 * longint'(pos_x) - 2 * rx2 * longint'(pos_y) + ry2;
                end
            end
            else begin
                if (err_term <= 0) begin
                    pos_x = pos_x + 1'b1;
                    pos_y = pos_y - 1'b1;
                    err_term += 4 * (2 * ry2 * longint'(pos_x)
                                     - 2 * rx2 * longint'(pos_y) + rx2);
                end
                else begin
                    pos_y = pos_y - 1'b1;
                    err_term += 4 * (rx2 - 2 * rx2 * longint'(pos_y));
                end
            end
            check_region_change();
            x  = longint'(pos_x);
            y  = longint'(pos_y);
            cx = longint'(cen_x);
            cy = longint'(cen_y);
            push_pixel(cx + x, cy + y, 1'b0);
            push_pixel(cx + x, cy - y, 1'b0);
            push_pixel(cx - x, cy + y, 1'b0);
            push_pixel(cx - x, cy - y, complete);
        endfunction

        function void check_pixel(pixel_t got);
            pixel_t want;
            checked++;
            if (pending.size() == 0) begin
                $error("unexpected pixel x=%0d y=%0d final_pixel=%0b",
                       got.px, got.py, got.last);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.px !== want.px) begin
                $error("pixel_x: expected %0d, got %0d", want.px, got.px);
                errors++;
            end
            if (got.py !== want.py) begin
                $error("pixel_y: expected %0d, got %0d", want.py, got.py);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("final_pixel: expected %0b, got %0b", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    mer_step_if  step_if ();
    mer_pixel_if pixel_if ();

    ellipse_walk_model walks;

    int send_idle     = 28;
    int recv_idle     = 82;
    int cycles        = 0;
    int counted_items = 0;
    int restarts_sent = 0;
    int steps_sent    = 0;
    int reg_writes    = 0;

    midpoint_ellipse_rasterizer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (step_if),
        .pixel     (pixel_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("[midpoint_ellipse_rasterizer] ERROR");
            $finish;
        end
    end

    // pixel side: random stalls and the check of every transfer
    always @(posedge clk)
    begin : pixel_monitor
        pixel_t got;
        pixel_if.ready <= rst_n && ($urandom_range(99) >= recv_idle);
        if (rst_n && pixel_if.valid && pixel_if.ready)
        begin
            got.px   = pixel_if.pixel_x;
            got.py   = pixel_if.pixel_y;
            got.last = pixel_if.final_pixel;
            walks.check_pixel(got);
        end
    end

    task automatic send_step(input bit restart);
        counted_items++;
        while ($urandom_range(99) < send_idle)
        begin
            step_if.valid <= 1'b0;
            @(posedge clk);
        end
        step_if.valid   <= 1'b1;
        step_if.restart <= restart;
        @(posedge clk);
        while (!step_if.ready)
            @(posedge clk);
        walks.note_step(restart);
        if (restart)
            restarts_sent++;
        else
            steps_sent++;
    endtask

    // hold off new steps until every owed pixel has arrived
    task automatic pause_until_drained(input int settle_cycles);
        step_if.valid <= 1'b0;
        @(posedge clk);
        while (walks.pending.size() != 0)
            @(posedge clk);
        repeat (settle_cycles) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        walks.write_reg(idx, val);
        reg_writes++;
        @(posedge clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_value(input logic [CFG_IDX_W-1:0] idx);
        int roll = $urandom_range(99);
        if (idx == CFG_CENTER_X || idx == CFG_CENTER_Y)
        begin
            if (roll < 10)
                return '0;
            if (roll < 20)
                return CFG_DATA_W'(CENTER_MAX);
            return CFG_DATA_W'($urandom_range(CENTER_MAX));
        end
        // mostly small radii so that whole walks stay short
        if (roll < 2)
            return '0;
        if (roll < 6)
            return CFG_DATA_W'(RADIUS_MAX);
        if (roll < 10)
            return CFG_DATA_W'($urandom_range(RADIUS_MAX - 1, 61));
        if (roll < 25)
            return CFG_DATA_W'($urandom_range(60, 13));
        return CFG_DATA_W'($urandom_range(12, 1));
    endfunction

    task automatic run_walk(input int max_steps, input int tail, input bit disturb);
        int n = 0;
        int roll;
        int pick;
        send_step(1'b1);
        while (!walks.complete && n < max_steps)
        begin
            if (disturb)
            begin
                roll = $urandom_range(99);
                if (roll < 3)
                    pause_until_drained(0);
                else if (roll < 5)
                begin
                    // register change in the middle of a walk
                    pause_until_drained(SETTLE_CYCLES);
                    pick = $urandom_range(3);
                    write_reg(REG_LIST[pick], pick_value(REG_LIST[pick]));
                end
                else if (roll < 6)
                    send_step(1'b1);
            end
            send_step(1'b0);
            n++;
        end
        repeat (tail) send_step(1'b0);
    endtask

    initial
    begin
        int start;
        int progress;
        int max_steps;
        walks = new();
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= CFG_CENTER_X;
        cfg_data        <= '0;
        step_if.valid   <= 1'b0;
        step_if.restart <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk is finished out of reset, these steps draw nothing
        send_step(1'b0);
        send_step(1'b0);
        // unit circle at the origin: negative pixels and an immediate end
        run_walk(8, 1, 1'b0);

        pause_until_drained(SETTLE_CYCLES);
        write_reg(CFG_CENTER_X, CFG_DATA_W'(CENTER_MAX));
        write_reg(CFG_CENTER_Y, CFG_DATA_W'(CENTER_MAX));
        write_reg(CFG_RADIUS_X, CFG_DATA_W'(RADIUS_MAX));
        write_reg(CFG_RADIUS_Y, CFG_DATA_W'(RADIUS_MAX));
        send_step(1'b1);
        repeat (3) send_step(1'b0);

        // radius and center moved while the walk is under way
        pause_until_drained(SETTLE_CYCLES);
        write_reg(CFG_RADIUS_Y, CFG_DATA_W'(200));
        write_reg(CFG_CENTER_X, '0);
        repeat (2) send_step(1'b0);

        // zero radius on either axis draws nothing
        pause_until_drained(SETTLE_CYCLES);
        write_reg(CFG_RADIUS_X, '0);
        send_step(1'b1);
        send_step(1'b0);
        pause_until_drained(SETTLE_CYCLES);
        write_reg(CFG_RADIUS_X, CFG_DATA_W'(5));
        write_reg(CFG_RADIUS_Y, '0);
        send_step(1'b1);
        send_step(1'b0);

        // small full walk through both regions, sender held once mid-walk
        pause_until_drained(SETTLE_CYCLES);
        write_reg(CFG_CENTER_Y, '0);
        write_reg(CFG_RADIUS_X, CFG_DATA_W'(2));
        write_reg(CFG_RADIUS_Y, CFG_DATA_W'(3));
        send_step(1'b1);
        send_step(1'b0);
        pause_until_drained(0);
        while (!walks.complete)
            send_step(1'b0);
        send_step(1'b0);

        start = counted_items;
        while (counted_items - start < RANDOM_ITEMS)
        begin
            progress = counted_items - start;
            if (progress < RANDOM_ITEMS / 3)
            begin
                send_idle = 28;
                recv_idle = 82;
            end
            else if (progress < 2 * RANDOM_ITEMS / 3)
            begin
                send_idle = 82;
                recv_idle = 28;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            pause_until_drained(SETTLE_CYCLES);
            foreach (REG_LIST[i])
                if ($urandom_range(1))
                    write_reg(REG_LIST[i], pick_value(REG_LIST[i]));
            if ($urandom_range(99) < 15)
                max_steps = $urandom_range(8, 1);
            else if (walks.rad_x > 60 || walks.rad_y > 60)
                max_steps = $urandom_range(60, 20);
            else
                max_steps = 1000;
            run_walk(max_steps, $urandom_range(2), 1'b1);
        end

        pause_until_drained(SETTLE_CYCLES);
        $display("covered %0d restarts, %0d steps, %0d pixels, %0d register writes",
                 restarts_sent, steps_sent, walks.checked, reg_writes);
        $display("radii 0 to max, centers 0 to max, idling on either side and on neither");
        if (walks.errors == 0 && walks.pending.size() == 0)
            $display("[midpoint_ellipse_rasterizer] OK");
        else
            $display("[midpoint_ellipse_rasterizer] ERROR");
        $finish;
    end

endmodule
